>>> design/wwsm_pkg.sv
// Shared types and constants for the windowed working-set monitor.
// Used by wwsm_out_reg and the top-level module; no dependencies.
package wwsm_pkg;

  localparam int CNT_W   = 24;
  localparam int WIN_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int KIND_W  = 3;
  localparam int NBLOCKS = 32;
  localparam int BLK_W   = 5;

  localparam int DEF_ADDR_BITS  = 32;
  localparam int DEF_PAGE_OFS_W = 12;
  localparam int DEF_BLK_LSB    = 27;

  localparam logic [CNT_W-1:0] WLEN_RESET = 24'd100000;

  // access kinds at or below ACC_WRITE are data references, above ACC_OTHER invalid
  localparam logic [KIND_W-1:0] ACC_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] ACC_OTHER = 3'd3;

  typedef enum logic [1:0] {
    REC_SUMMARY = 2'd0,
    REC_BLOCK   = 2'd1,
    REC_ERROR   = 2'd2
  } rec_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [KIND_W-1:0] access_kind;
  } in_item_t;

  typedef struct packed {
    rec_kind_t         record_kind;
    logic [WIN_W-1:0]  window_number;
    logic [BLK_W-1:0]  block_index;
    logic [CNT_W-1:0]  count_value;
    logic [CNT_W-1:0]  data_total;
    logic              last_record;
  } out_item_t;

endpackage

>>> design/wwsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wwsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/wwsm_out_reg.sv
// Output register for result items: holds one item until the receiver takes it.
// Depends on wwsm_pkg.
module wwsm_out_reg
  import wwsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  // slot may be refilled in the same cycle that the held item leaves
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      item_r <= load_item;
    end
  end

endmodule

>>> design/windowed_working_set_monitor.sv
// Windowed working-set monitor, top level.
// Depends on wwsm_pkg, wwsm_ram and wwsm_out_reg.
//
// Usage:
//   in_valid/in_stall/in_item carry memory references (address, access kind).
//   out_valid/out_stall/out_item carry result items. cfg_we/cfg_wdata write
//   the window length; write it only while the block is idle.
//   A valid reference is accepted, then the page bitmap row and the block
//   counter get a read-modify-write in S_UPD; it gives no result unless it
//   closes a window. An invalid kind gives one error item through S_ERR and
//   the output register and touches no state.
//   When a reference closes a window, the summary item comes out through
//   S_UPD, S_SUM and the output register, then the block counter memory is
//   swept through S_BLK_RD and S_BLK_EMIT per block (32 blocks), emitting
//   one item per nonzero count. The page bitmap is then cleared one 32-bit
//   row per cycle, 2^(ADDR_BITS-PAGE_OFS_W-5) rows, 32768 at the defaults.
//   in_stall stays high during the sweep and the clear.
//   Reset (synchronous, rst_n low) starts the same bitmap clear; in_stall
//   is high until it finishes.
//   A stalled receiver holds the output register; the block then waits in
//   whichever state has the next result, and a reference that gives no
//   result is still accepted while an earlier result waits.
module windowed_working_set_monitor
  import wwsm_pkg::*;
#(
  parameter int ADDR_BITS  = DEF_ADDR_BITS,
  parameter int PAGE_OFS_W = DEF_PAGE_OFS_W,
  parameter int BLK_LSB    = DEF_BLK_LSB
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int PG_BITS   = ADDR_BITS - PAGE_OFS_W;
  localparam int ROW_LG    = (PG_BITS > 5) ? 5 : PG_BITS - 1;
  localparam int ROW_W     = 1 << ROW_LG;
  localparam int ROW_IDX_W = PG_BITS - ROW_LG;
  localparam int PAGE_ROWS = 1 << ROW_IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_ERR,
    S_SUM,
    S_BLK_RD,
    S_BLK_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ROW_IDX_W-1:0]   clr_r, clr_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  logic [NBLOCKS-1:0]     mask_r, mask_nxt;
  logic [CNT_W-1:0]       uniq_r, uniq_nxt;
  logic [CNT_W-1:0]       wrefs_r, wrefs_nxt;
  logic [CNT_W-1:0]       drefs_r, drefs_nxt;
  logic [WIN_W-1:0]       win_r, win_nxt;
  logic [CNT_W-1:0]       len_r;

  // captured reference (payload, no reset)
  logic [ROW_IDX_W-1:0]   row_r;
  logic [ROW_LG-1:0]      bit_r;
  logic [BLK_W-1:0]       bsel_r;
  logic                   data_r;

  logic                   accept;
  logic [31:0]            a32;
  logic [31:0]            page_no;
  logic [ROW_IDX_W-1:0]   in_row;
  logic [ROW_LG-1:0]      in_bit;
  logic [BLK_W-1:0]       in_blk;

  logic                   pg_we;
  logic [ROW_IDX_W-1:0]   pg_waddr;
  logic [ROW_W-1:0]       pg_wdata;
  logic [ROW_W-1:0]       pg_rdata;
  logic [ROW_W-1:0]       bit_oh;
  logic                   seen;

  logic                   bc_we;
  logic [BLK_W-1:0]       bc_raddr;
  logic [CNT_W-1:0]       bc_rdata;
  logic [CNT_W-1:0]       cnt_old;
  logic [CNT_W-1:0]       cnt_new;
  logic [CNT_W-1:0]       wr_inc;
  logic [NBLOCKS-1:0]     mask_hi;

  logic                   out_free;
  logic                   emit;
  out_item_t              emit_item;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // address fields of the incoming reference
  assign a32     = 32'(in_item.address[ADDR_BITS-1:0]);
  assign page_no = a32 >> PAGE_OFS_W;
  assign in_row  = page_no[PG_BITS-1:ROW_LG];
  assign in_bit  = page_no[ROW_LG-1:0];
  assign in_blk  = BLK_W'(a32 >> BLK_LSB);

  // page bitmap: read at acceptance, set the bit in the following cycle (S_UPD)
  assign bit_oh   = ROW_W'(1) << bit_r;
  assign seen     = |(pg_rdata & bit_oh);
  assign pg_we    = (state_r == S_CLEAR) || (state_r == S_UPD && data_r && !seen);
  assign pg_waddr = (state_r == S_CLEAR) ? clr_r : row_r;
  assign pg_wdata = (state_r == S_CLEAR) ? '0 : (pg_rdata | bit_oh);

  wwsm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PAGE_ROWS)
  ) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (in_row),
    .rdata (pg_rdata)
  );

  // block counters: entries without a mask bit read as zero
  assign bc_raddr = (state_r == S_IDLE) ? in_blk : blk_r;
  assign cnt_old  = mask_r[bsel_r] ? bc_rdata : '0;
  assign cnt_new  = cnt_old + CNT_W'(1);
  assign bc_we    = (state_r == S_UPD) && data_r;

  wwsm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NBLOCKS)
  ) u_block_ram (
    .clk   (clk),
    .we    (bc_we),
    .waddr (bsel_r),
    .wdata (cnt_new),
    .raddr (bc_raddr),
    .rdata (bc_rdata)
  );

  assign wr_inc  = wrefs_r + CNT_W'(1);
  assign mask_hi = mask_r >> blk_r;

  wwsm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .load_item (emit_item),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    blk_nxt   = blk_r;
    mask_nxt  = mask_r;
    uniq_nxt  = uniq_r;
    wrefs_nxt = wrefs_r;
    drefs_nxt = drefs_r;
    win_nxt   = win_r;
    emit      = 1'b0;
    emit_item = '{record_kind: REC_ERROR, window_number: win_r, block_index: '0,
                  count_value: '0, data_total: '0, last_record: 1'b1};
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ROW_IDX_W'(1);
        if (clr_r == ROW_IDX_W'(PAGE_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.access_kind > ACC_OTHER) ? S_ERR : S_UPD;
        end
      end
      S_UPD: begin
        wrefs_nxt = wr_inc;
        if (data_r) begin
          drefs_nxt        = drefs_r + CNT_W'(1);
          uniq_nxt         = seen ? uniq_r : uniq_r + CNT_W'(1);
          mask_nxt[bsel_r] = |cnt_new;
        end
        state_nxt = (wr_inc >= len_r) ? S_SUM : S_IDLE;
      end
      S_ERR: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = '{record_kind: REC_SUMMARY, window_number: win_r, block_index: '0,
                        count_value: uniq_r, data_total: drefs_r,
                        last_record: (mask_r == '0)};
          blk_nxt   = '0;
          state_nxt = S_BLK_RD;
        end
      end
      S_BLK_RD: begin
        state_nxt = S_BLK_EMIT;
      end
      S_BLK_EMIT: begin
        if (!mask_r[blk_r] || out_free) begin
          if (mask_r[blk_r]) begin
            emit      = 1'b1;
            emit_item = '{record_kind: REC_BLOCK, window_number: win_r, block_index: blk_r,
                          count_value: bc_rdata, data_total: '0,
                          last_record: (mask_hi[NBLOCKS-1:1] == '0)};
          end
          blk_nxt   = blk_r + BLK_W'(1);
          state_nxt = S_BLK_RD;
          // window closed: drop counters, then clear the page bitmap
          if (blk_r == BLK_W'(NBLOCKS - 1)) begin
            mask_nxt  = '0;
            uniq_nxt  = '0;
            wrefs_nxt = '0;
            drefs_nxt = '0;
            win_nxt   = win_r + WIN_W'(1);
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      blk_r   <= '0;
      mask_r  <= '0;
      uniq_r  <= '0;
      wrefs_r <= '0;
      drefs_r <= '0;
      win_r   <= '0;
      len_r   <= WLEN_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      blk_r   <= blk_nxt;
      mask_r  <= mask_nxt;
      uniq_r  <= uniq_nxt;
      wrefs_r <= wrefs_nxt;
      drefs_r <= drefs_nxt;
      win_r   <= win_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
    if (accept) begin
      row_r  <= in_row;
      bit_r  <= in_bit;
      bsel_r <= in_blk;
      data_r <= (in_item.access_kind <= ACC_WRITE);
    end
  end

endmodule
